[rtl/kdlz_pkg.sv]
// Package for the keyed escape-byte LZ decompressor.
// Holds the decode phase type, status codes, the XOR key table and sizes.
// No dependencies.
package kdlz_pkg;

  typedef enum logic [2:0] {
    PH_HDR  = 3'd0,
    PH_TOK  = 3'd1,
    PH_ESC  = 3'd2,
    PH_EXT  = 3'd3,
    PH_DIST = 3'd4,
    PH_COPY = 3'd5,
    PH_DONE = 3'd6
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_BAD_HDR   = 4'd1,
    ST_OVER_SIZE = 4'd2,
    ST_TRUNC_ESC = 4'd3,
    ST_TRUNC_LEN = 4'd4,
    ST_BAD_REF   = 4'd5,
    ST_REF_OOB   = 4'd6,
    ST_SIZE_MISM = 4'd7,
    ST_BYTE_COPY = 4'd8
  } status_t;

  localparam int unsigned KEY_LEN = 12;

  typedef struct packed {
    logic       copy;
    logic       wr;
    logic [7:0] lit;
    logic       valid;
    logic       done;
    status_t    status;
    logic       pending;
  } s2_meta_t;

  function automatic logic [7:0] key_byte(input logic [3:0] pos);
    logic [7:0] k;
    unique case (pos)
      4'd0:    k = 8'h55;
      4'd1:    k = 8'haa;
      4'd2:    k = 8'h20;
      4'd3:    k = 8'h55;
      4'd4:    k = 8'h55;
      4'd5:    k = 8'h06;
      4'd6:    k = 8'h55;
      4'd7:    k = 8'haa;
      4'd8:    k = 8'h55;
      4'd9:    k = 8'hd5;
      4'd10:   k = 8'h7c;
      4'd11:   k = 8'h66;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

endpackage

[rtl/kdlz_hist_ram.sv]
// History memory of the decompressor: one write port, one registered read port.
// Depends on nothing.
module kdlz_hist_ram #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/keyed_escape_lz_decompressor_unit.sv]
// Top level of the keyed escape-byte LZ decompressor.
// Depends on kdlz_pkg and kdlz_hist_ram.
//
// Usage: stored archive bytes enter on the in_ channel (tuser 0) and drain
// ticks (tuser 1) pull one copied byte each while a back-reference is pending.
// Results leave on the out_ channel; a beat that produces nothing is simply
// consumed. Registers are to be written through cfg_ only while the block is
// idle; the block does not enforce this. Every beat is decoded in the cycle
// it is accepted. A copy beat reads the history memory in that cycle, the read
// data arrives in the next cycle in the second stage, where the byte is
// written back to history; a write in the second stage to the address being
// read is forwarded. The result then moves on into the output register when
// the output advances. Throughput is one beat per cycle while the output does
// not stall, bounded by the single memory read port. Reset clears all decode
// state; history content is left undefined and is never read before being
// written. When the receiver stalls, the output register and the second stage
// hold and in_tready drops only once both are full.
module keyed_escape_lz_decompressor_unit #(
  parameter int unsigned HISTORY_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [23:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // kind
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_byte, status, copy_pending, zero fill
  output logic        out_tuser,  // byte_valid
  output logic        out_tlast   // stream_done
);
  import kdlz_pkg::*;

  localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [AW:0]  DEPTH_W = (AW+1)'(HISTORY_DEPTH);
  localparam logic [25:0]  DEPTH_D = 26'(HISTORY_DEPTH);

  localparam logic [1:0] REG_KEYED = 2'd0;
  localparam logic [1:0] REG_PHASE = 2'd1;
  localparam logic [1:0] REG_SIZE  = 2'd2;

  logic        keyed_r;
  logic [3:0]  kstart_r;
  logic [23:0] exp_r;

  phase_t      phase_r, phase_nxt;
  logic [31:0] hs_r, hs_nxt;
  logic [3:0]  hc_r, hc_nxt;
  logic [3:0]  kp_r, kp_nxt;
  logic [7:0]  esc_r, esc_nxt;
  logic [7:0]  tok_r, tok_nxt;
  logic [1:0]  dbl_r, dbl_nxt;
  logic [23:0] dv_r, dv_nxt;
  logic [13:0] rem_r, rem_nxt;
  logic [24:0] prod_r, prod_nxt;
  logic [31:0] pk_r, pk_nxt;
  logic [31:0] dp_r, dp_nxt;
  logic        end_r, end_nxt;
  logic        fail_r, fail_nxt;
  logic [AW-1:0] wp_r, wp_nxt;

  s2_meta_t    s2_r, s2_nxt;
  logic        s2_valid_r;
  logic [AW-1:0] s2_addr_r;
  logic        fwd_r;
  logic [7:0]  fwd_byte_r;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_bv_r, out_done_r, out_pend_r;
  status_t     out_st_r;

  logic        accept, advance, res, rd_en, hist_wr;
  logic [AW-1:0] rd_idx;
  logic [7:0]  mem_q, s2_byte;
  logic [3:0]  kstart_mod;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s2_valid_r || advance;
  assign accept    = in_tvalid && in_tready;
  assign kstart_mod = (cfg_wdata[3:0] >= 4'(KEY_LEN)) ? cfg_wdata[3:0] - 4'(KEY_LEN)
                                                       : cfg_wdata[3:0];

  always_comb begin
    logic [7:0]  b;
    logic [32:0] pc;
    logic        bad_pc, fail_en, lit_en, sd_en;
    status_t     fail_code;
    logic [7:0]  lit_b, sd_tc, tc;
    logic [2:0]  total;
    logic [1:0]  pos;
    logic [24:0] back_dist;
    logic [14:0] cnt;
    logic [AW:0] diff;
    logic [AW:0] shift;
    phase_nxt = phase_r; hs_nxt = hs_r; hc_nxt = hc_r; kp_nxt = kp_r;
    esc_nxt = esc_r; tok_nxt = tok_r; dbl_nxt = dbl_r; dv_nxt = dv_r;
    rem_nxt = rem_r; prod_nxt = prod_r; pk_nxt = pk_r; dp_nxt = dp_r;
    end_nxt = end_r; fail_nxt = fail_r; wp_nxt = wp_r;
    s2_nxt = '0; res = 1'b0; rd_en = 1'b0; hist_wr = 1'b0;
    fail_en = 1'b0; fail_code = ST_OK; lit_en = 1'b0; lit_b = 8'd0;
    sd_en = 1'b0; sd_tc = 8'd0; tc = 8'd0;
    b = in_tdata; pc = 33'd0; bad_pc = 1'b0;
    total = 3'd0; pos = 2'd0; back_dist = 25'd0; cnt = 15'd0;
    shift = '0; diff = '0; rd_idx = '0;
    if (accept && phase_r != PH_DONE) begin
      if (in_tuser) begin
        if (phase_r == PH_COPY) begin
          shift = (AW+1)'(dv_r) + (AW+1)'(1);
          diff  = {1'b0, wp_r} - shift;
          rd_idx = diff[AW] ? AW'(diff + DEPTH_W) : diff[AW-1:0];
          rd_en = 1'b1;
          hist_wr = 1'b1;
          s2_nxt.copy = 1'b1;
          s2_nxt.wr = 1'b1;
          prod_nxt = prod_r + 25'd1;
          rem_nxt = rem_r - 14'd1;
          res = 1'b1;
          s2_nxt.valid = 1'b1;
          if (rem_nxt == 14'd0) begin
            phase_nxt = PH_TOK;
            if (end_r) begin
              phase_nxt = PH_DONE;
              s2_nxt.done = 1'b1;
              s2_nxt.status = (prod_nxt == {1'b0, exp_r}) ? ST_OK : ST_SIZE_MISM;
            end
          end
        end
      end else if (phase_r == PH_COPY) begin
        fail_en = 1'b1; fail_code = ST_BYTE_COPY;
      end else begin
        if (keyed_r) b = in_tdata ^ key_byte(kp_r);
        kp_nxt = (kp_r >= 4'(KEY_LEN - 1)) ? 4'd0 : kp_r + 4'd1;
        pc = {1'b0, pk_r} + 33'd1;
        pk_nxt = pc[31:0];
        if (phase_r == PH_HDR) begin
          hs_nxt = {b, hs_r[31:8]};
          hc_nxt = hc_r + 4'd1;
          if (hc_r == 4'd7) dp_nxt = hs_nxt;
          bad_pc = in_tlast ? (pc != {1'b0, dp_nxt}) : (pc > {1'b0, dp_nxt});
          if (hc_r == 4'd3 && hs_nxt != {8'd0, exp_r}) begin
            fail_en = 1'b1; fail_code = ST_BAD_HDR;
          end else if (hc_r < 4'd7) begin
            if (in_tlast) begin
              fail_en = 1'b1; fail_code = ST_BAD_HDR;
            end
          end else if (bad_pc) begin
            fail_en = 1'b1; fail_code = ST_BAD_HDR;
          end else if (hc_r == 4'd8) begin
            esc_nxt = b;
            phase_nxt = PH_TOK;
            if (in_tlast) begin
              phase_nxt = PH_DONE;
              end_nxt = 1'b1;
              res = 1'b1;
              s2_nxt.done = 1'b1;
              s2_nxt.status = (prod_r == {1'b0, exp_r}) ? ST_OK : ST_SIZE_MISM;
            end
          end else if (in_tlast) begin
            fail_en = 1'b1; fail_code = ST_BAD_HDR;
          end
        end else begin
          bad_pc = in_tlast ? (pc != {1'b0, dp_r}) : (pc > {1'b0, dp_r});
          if (bad_pc) begin
            fail_en = 1'b1; fail_code = ST_BAD_HDR;
          end else begin
            unique case (phase_r)
              PH_TOK: begin
                if (b != esc_r) begin
                  lit_en = 1'b1; lit_b = b;
                end else if (in_tlast) begin
                  fail_en = 1'b1; fail_code = ST_TRUNC_ESC;
                end else begin
                  phase_nxt = PH_ESC;
                end
              end
              PH_ESC: begin
                if (b == esc_r) begin
                  phase_nxt = PH_TOK;
                  lit_en = 1'b1; lit_b = b;
                end else begin
                  tc = (b > esc_r) ? b - 8'd1 : b;
                  tok_nxt = tc;
                  rem_nxt = {9'd0, tc[7:3]};
                  if (tc[2]) begin
                    if (in_tlast) begin
                      fail_en = 1'b1; fail_code = ST_TRUNC_LEN;
                    end else begin
                      phase_nxt = PH_EXT;
                    end
                  end else begin
                    sd_en = 1'b1; sd_tc = tc;
                  end
                end
              end
              PH_EXT: begin
                rem_nxt = rem_r | {1'b0, b, 5'd0};
                sd_en = 1'b1; sd_tc = tok_r;
              end
              default: begin
                total = {1'b0, tok_r[1:0]} + 3'd1;
                pos = 2'(total - {1'b0, dbl_r});
                dv_nxt = dv_r | (24'(b) << {pos, 3'd0});
                dbl_nxt = dbl_r - 2'd1;
                if (dbl_nxt != 2'd0) begin
                  if (in_tlast) begin
                    fail_en = 1'b1; fail_code = ST_BAD_REF;
                  end
                end else begin
                  back_dist = {1'b0, dv_nxt} + 25'd1;
                  cnt = {1'b0, rem_r} + 15'd4;
                  if (back_dist > prod_r || {1'b0, back_dist} > DEPTH_D ||
                      ({1'b0, prod_r} + 26'(cnt)) > {2'd0, exp_r}) begin
                    fail_en = 1'b1; fail_code = ST_REF_OOB;
                  end else begin
                    rem_nxt = cnt[13:0];
                    end_nxt = in_tlast;
                    phase_nxt = PH_COPY;
                    res = 1'b1;
                  end
                end
              end
            endcase
          end
        end
      end
      if (sd_en) begin
        if (sd_tc[1:0] == 2'd3 || in_tlast) begin
          fail_en = 1'b1; fail_code = ST_BAD_REF;
        end else begin
          dbl_nxt = sd_tc[1:0] + 2'd1;
          dv_nxt = 24'd0;
          phase_nxt = PH_DIST;
        end
      end
      if (lit_en) begin
        if (prod_r >= {1'b0, exp_r}) begin
          fail_en = 1'b1; fail_code = ST_OVER_SIZE;
        end else begin
          hist_wr = 1'b1;
          s2_nxt.wr = 1'b1;
          s2_nxt.lit = lit_b;
          prod_nxt = prod_r + 25'd1;
          res = 1'b1;
          s2_nxt.valid = 1'b1;
          if (in_tlast) begin
            phase_nxt = PH_DONE;
            end_nxt = 1'b1;
            s2_nxt.done = 1'b1;
            s2_nxt.status = (prod_nxt == {1'b0, exp_r}) ? ST_OK : ST_SIZE_MISM;
          end
        end
      end
      if (fail_en) begin
        phase_nxt = PH_DONE;
        fail_nxt = 1'b1;
        rem_nxt = 14'd0;
        res = 1'b1;
        s2_nxt = '0;
        hist_wr = 1'b0;
        rd_en = 1'b0;
        prod_nxt = prod_r;
        s2_nxt.done = 1'b1;
        s2_nxt.status = fail_code;
      end
      if (hist_wr) begin
        wp_nxt = (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      s2_nxt.pending = (phase_nxt == PH_COPY);
    end
    if (cfg_we && cfg_addr == REG_PHASE && pk_r == 32'd0 && phase_r == PH_HDR) begin
      kp_nxt = kstart_mod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keyed_r <= 1'b1;
      kstart_r <= 4'd0;
      exp_r <= 24'd0;
      phase_r <= PH_HDR;
      hs_r <= '0; hc_r <= '0; kp_r <= '0; esc_r <= '0; tok_r <= '0;
      dbl_r <= '0; dv_r <= '0; rem_r <= '0; prod_r <= '0; pk_r <= '0;
      dp_r <= '0; end_r <= 1'b0; fail_r <= 1'b0; wp_r <= '0;
    end else begin
      phase_r <= phase_nxt; hs_r <= hs_nxt; hc_r <= hc_nxt; kp_r <= kp_nxt;
      esc_r <= esc_nxt; tok_r <= tok_nxt; dbl_r <= dbl_nxt; dv_r <= dv_nxt;
      rem_r <= rem_nxt; prod_r <= prod_nxt; pk_r <= pk_nxt; dp_r <= dp_nxt;
      end_r <= end_nxt; fail_r <= fail_nxt; wp_r <= wp_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_KEYED: keyed_r <= cfg_wdata[0];
          REG_PHASE: kstart_r <= cfg_wdata[3:0];
          REG_SIZE: exp_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign s2_byte = s2_r.copy ? (fwd_r ? fwd_byte_r : mem_q) : s2_r.lit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s2_valid_r <= res;
      end else if (advance) begin
        s2_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_r <= s2_nxt;
      s2_addr_r <= wp_r;
      fwd_r <= s2_valid_r && s2_r.wr && (s2_addr_r == rd_idx);
      fwd_byte_r <= s2_byte;
    end
    if (advance && s2_valid_r) begin
      out_byte_r <= s2_r.valid ? s2_byte : 8'd0;
      out_bv_r <= s2_r.valid;
      out_done_r <= s2_r.done;
      out_st_r <= s2_r.status;
      out_pend_r <= s2_r.pending;
    end
  end

  kdlz_hist_ram #(
    .DEPTH(HISTORY_DEPTH),
    .AW   (AW)
  ) u_hist (
    .clk  (clk),
    .we   (s2_valid_r && s2_r.wr && advance),
    .waddr(s2_addr_r),
    .wdata(s2_byte),
    .re   (rd_en),
    .raddr(rd_idx),
    .rdata(mem_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_pend_r, out_st_r, out_byte_r};
  assign out_tuser  = out_bv_r;
  assign out_tlast  = out_done_r;

  logic unused_ok;
  assign unused_ok = fail_r ^ (|kstart_r);

  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |=> phase_r == PH_DONE)
    else $error("decoder left the done phase");
  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !advance) |-> !in_tready)
    else $error("beat accepted while second stage is stalled");
  a_done_not_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> !out_pend_r)
    else $error("stream ended with a copy still pending");

endmodule

[tb/keyed_escape_lz_decompressor_unit_test.sv]
// Self-checking testbench for keyed_escape_lz_decompressor_unit.
// Holds one encoded stream, an in-bench decoder that predicts every result, and a scoreboard.
// Depends on kdlz_pkg and the unit's RTL only.
module keyed_escape_lz_decompressor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kdlz_pkg::*;

  localparam int unsigned DEPTH = 65536;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LATENCY = 8;
  localparam logic [1:0] REG_KEYED = 2'd0;
  localparam logic [1:0] REG_KEY_PHASE = 2'd1;
  localparam logic [1:0] REG_SIZE = 2'd2;
  localparam logic [7:0] XOR_KEY [12] = '{8'h55, 8'haa, 8'h20, 8'h55, 8'h55, 8'h06,
                                          8'h55, 8'haa, 8'h55, 8'hd5, 8'h7c, 8'h66};

  typedef struct {
    bit       kind;
    bit [7:0] data;
    bit       last;
  } beat_t;

  typedef struct {
    bit [7:0] ob;
    bit       valid;
    bit       done;
    status_t  st;
    bit       pend;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [23:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // data_byte
  logic        in_tuser;   // kind
  logic        in_tlast;   // last_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // out_byte, status, copy_pending, zero fill
  logic        out_tuser;  // byte_valid
  logic        out_tlast;  // stream_done

  keyed_escape_lz_decompressor_unit dut (.*);

  always #1 clk = ~clk;

  // Decoder state and register copies.
  bit          m_keyed;
  int unsigned m_key_phase, m_size;
  phase_t      ph;
  bit [31:0]   hshift, pcount, dpacked;
  int unsigned hcount, kpos, tok, dleft, dval, crem, prod;
  bit [7:0]    esc;
  bit          end_seen;
  bit [7:0]    hist [DEPTH];

  decoded_t    decoded_q[$];
  beat_t       stream_q[$];
  int unsigned send_idle, stall_pct, fails, cycles;
  bit [7:0]    g_esc;
  int unsigned g_prod;

  function automatic status_t end_status();
    return (prod == m_size) ? ST_OK : ST_SIZE_MISM;
  endfunction

  function automatic void post(bit [7:0] b, bit v, bit d, status_t st);
    decoded_t r;
    r.ob = b; r.valid = v; r.done = d; r.st = st; r.pend = (ph == PH_COPY);
    decoded_q = {decoded_q, r};
  endfunction

  function automatic void abort(status_t st);
    ph = PH_DONE;
    crem = 0;
    post(8'h00, 1'b0, 1'b1, st);
  endfunction

  function automatic void put_hist(bit [7:0] b);
    hist[prod % DEPTH] = b;
    prod = (prod + 1) & 32'h1ffffff;
  endfunction

  function automatic void literal(bit [7:0] b, bit last);
    if (prod >= m_size) begin
      abort(ST_OVER_SIZE);
      return;
    end
    put_hist(b);
    if (last) begin
      ph = PH_DONE;
      end_seen = 1'b1;
      post(b, 1'b1, 1'b1, end_status());
    end else begin
      post(b, 1'b1, 1'b0, ST_OK);
    end
  endfunction

  function automatic void start_distance(bit last);
    if ((tok & 3) == 3 || last) begin
      abort(ST_BAD_REF);
      return;
    end
    dleft = (tok & 3) + 1;
    dval = 0;
    ph = PH_DIST;
  endfunction

  function automatic void decode_beat(bit kind, bit [7:0] bin, bit last);
    bit [7:0] b, v;
    int unsigned hc, idx, total, pos;
    longint unsigned pc, back_dist, cnt;
    b = bin;
    if (ph == PH_DONE) return;
    if (kind) begin
      if (ph != PH_COPY) return;
      idx = (prod % DEPTH + DEPTH - (dval + 1)) % DEPTH;
      v = hist[idx];
      put_hist(v);
      crem = (crem - 1) & 32'h3fff;
      if (crem == 0) begin
        ph = PH_TOK;
        if (end_seen) begin
          ph = PH_DONE;
          post(v, 1'b1, 1'b1, end_status());
          return;
        end
      end
      post(v, 1'b1, 1'b0, ST_OK);
      return;
    end
    if (ph == PH_COPY) begin
      abort(ST_BYTE_COPY);
      return;
    end
    if (m_keyed) b ^= XOR_KEY[kpos % 12];
    kpos = (kpos % 12 + 1) % 12;
    pc = longint'(pcount) + 1;
    pcount = pc[31:0];
    if (ph == PH_HDR) begin
      hc = hcount;
      hshift = {b, hshift[31:8]};
      hcount = hc + 1;
      if (hc == 3 && hshift != m_size) begin
        abort(ST_BAD_HDR);
        return;
      end
      if (hc == 7) dpacked = hshift;
      if (hc < 7) begin
        if (last) abort(ST_BAD_HDR);
        return;
      end
      if (last ? pc != dpacked : pc > dpacked) begin
        abort(ST_BAD_HDR);
        return;
      end
      if (hc == 8) begin
        esc = b;
        ph = PH_TOK;
        if (last) begin
          ph = PH_DONE;
          end_seen = 1'b1;
          post(8'h00, 1'b0, 1'b1, end_status());
        end
      end else if (last) begin
        abort(ST_BAD_HDR);
      end
      return;
    end
    if (last ? pc != dpacked : pc > dpacked) begin
      abort(ST_BAD_HDR);
      return;
    end
    case (ph)
      PH_TOK: begin
        if (b != esc) literal(b, last);
        else if (last) abort(ST_TRUNC_ESC);
        else ph = PH_ESC;
      end
      PH_ESC: begin
        if (b == esc) begin
          ph = PH_TOK;
          literal(b, last);
        end else begin
          tok = (b > esc) ? b - 1 : b;
          crem = tok >> 3;
          if (tok & 4) begin
            if (last) abort(ST_TRUNC_LEN);
            else ph = PH_EXT;
          end else begin
            start_distance(last);
          end
        end
      end
      PH_EXT: begin
        crem |= 32'(b) << 5;
        start_distance(last);
      end
      default: begin
        total = (tok & 3) + 1;
        pos = (total - dleft) & 3;
        dval = (dval | (32'(b) << (8 * pos))) & 32'hffffff;
        dleft = (dleft - 1) & 3;
        if (dleft != 0) begin
          if (last) abort(ST_BAD_REF);
          return;
        end
        back_dist = longint'(dval) + 1;
        cnt = longint'(crem) + 4;
        if (back_dist > prod || back_dist > DEPTH || longint'(prod) + cnt > m_size) begin
          abort(ST_REF_OOB);
          return;
        end
        crem = cnt & 32'h3fff;
        end_seen = last;
        ph = PH_COPY;
        post(8'h00, 1'b0, 1'b0, ST_OK);
      end
    endcase
  endfunction

  task automatic cfg_write(logic [1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[23:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_KEYED: m_keyed = val[0];
      REG_KEY_PHASE: begin
        m_key_phase = val & 4'hf;
        if (pcount == 0 && ph == PH_HDR) kpos = m_key_phase % 12;
      end
      default: m_size = val & 24'hffffff;
    endcase
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic send_beat(beat_t bt);
    bit [7:0] raw;
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    raw = bt.data;
    if (!bt.kind && m_keyed) raw ^= XOR_KEY[kpos % 12];
    in_tvalid <= 1'b1;
    in_tdata <= raw;
    in_tuser <= bt.kind;
    in_tlast <= bt.last;
    do @(posedge clk); while (!in_tready);
    decode_beat(bt.kind, raw, bt.last);
  endtask

  // Stream construction in plain (unkeyed) bytes.
  function automatic void push_byte(bit [7:0] b, bit last);
    beat_t bt;
    bt.kind = 1'b0; bt.data = b; bt.last = last;
    stream_q = {stream_q, bt};
  endfunction

  function automatic void push_ticks(int unsigned n);
    beat_t bt;
    repeat (n) begin
      bt.kind = 1'b1; bt.data = 8'($urandom); bt.last = 1'($urandom);
      stream_q = {stream_q, bt};
    end
  endfunction

  function automatic void gen_literal(bit [7:0] b, bit last);
    if (b == g_esc) push_byte(g_esc, 1'b0);
    push_byte(b, last);
    g_prod++;
  endfunction

  function automatic void gen_ref(int unsigned len, int unsigned back_dist, int unsigned nb,
                                  bit use_ext, bit last, int unsigned ticks);
    int unsigned span, d;
    bit [7:0] c;
    span = len - 4;
    d = back_dist - 1;
    c = {span[4:0], use_ext, 2'(nb - 1)};
    push_byte(g_esc, 1'b0);
    push_byte((c >= g_esc) ? c + 1 : c, 1'b0);
    if (use_ext) push_byte(8'(span >> 5), 1'b0);
    for (int i = 0; i < nb; i++) push_byte(d[8 * i +: 8], last && i == nb - 1);
    push_ticks(ticks);
    g_prod += len;
  endfunction

  function automatic void gen_random_ref(bit last, bit cut_short);
    int unsigned len, back_dist, nb;
    bit use_ext;
    use_ext = ($urandom_range(0, 3) == 0);
    len = 4 + (use_ext ? $urandom_range(0, 63) : $urandom_range(0, 31));
    back_dist = ($urandom_range(0, 3) == 0) ? $urandom_range(1, g_prod)
                                            : $urandom_range(1, (g_prod < 40) ? g_prod : 40);
    nb = (back_dist - 1 < 256) ? 1 : (back_dist - 1 < 65536) ? 2 : 3;
    nb = $urandom_range(nb, 3);
    gen_ref(len, back_dist, nb, use_ext, last, cut_short ? 2 : len);
  endfunction

  task automatic build_stream(output int unsigned end_mode);
    int unsigned r, packed_len;
    bit [7:0] hdr [9];
    g_esc = 8'($urandom);
    g_prod = 0;
    gen_literal(8'h00, 1'b0);
    gen_literal(8'hff, 1'b0);
    gen_literal(g_esc, 1'b0);
    push_ticks(1);
    gen_ref(4, 1, 1, 1'b0, 1'b0, 4);
    gen_ref(37, 3, 2, 1'b1, 1'b0, 37);
    gen_ref(35, 2, 3, 1'b0, 1'b0, 35);
    gen_literal(8'h5a, 1'b0);
    while (stream_q.size() < 1300) begin
      r = $urandom_range(0, 99);
      if (r < 55) gen_literal(($urandom_range(0, 9) == 0) ? g_esc : 8'($urandom), 1'b0);
      else if (r < 88) gen_random_ref(1'b0, 1'b0);
      else push_ticks(1);
    end
    end_mode = $urandom_range(0, 2);
    case (end_mode)
      0: gen_literal(8'($urandom), 1'b1);
      1: gen_random_ref(1'b1, 1'b0);
      default: begin
        gen_random_ref(1'b0, 1'b1);
        push_byte(8'($urandom), 1'b0);
      end
    endcase
    packed_len = 9;
    foreach (stream_q[i]) if (!stream_q[i].kind) packed_len++;
    hdr = '{8'hff, 8'hff, 8'hff, 8'h00, packed_len[7:0], packed_len[15:8],
            packed_len[23:16], packed_len[31:24], g_esc};
    for (int i = 8; i >= 0; i--) stream_q.push_front('{1'b0, hdr[i], 1'b0});
  endtask

  task automatic test_register_setup();
    cfg_write(REG_SIZE, 0);
    cfg_write(REG_KEY_PHASE, 11);
    cfg_write(REG_KEY_PHASE, 0);
    cfg_write(REG_KEY_PHASE, 15);
    cfg_write(REG_SIZE, 24'hffffff);
    cfg_write(REG_KEYED, $urandom_range(0, 1));
  endtask

  task automatic test_stream_phases();
    int unsigned end_mode, n, idx;
    int unsigned idle_tab [4] = '{0, 84, 0, 38};
    int unsigned stall_tab [4] = '{0, 0, 84, 38};
    build_stream(end_mode);
    n = stream_q.size();
    idx = 0;
    for (int p = 0; p < 4; p++) begin
      if (p > 0) begin
        wait_idle();
        cfg_write(REG_KEYED, !m_keyed);
        if (p == 1) cfg_write(REG_KEY_PHASE, $urandom_range(0, 15));
        if (p == 3) cfg_write(REG_SIZE, $urandom_range(0, 1) ? g_prod : 24'hffffff);
      end
      send_idle = idle_tab[p];
      stall_pct = stall_tab[p];
      while (idx < (p + 1) * n / 4) begin
        send_beat(stream_q[idx]);
        idx++;
      end
    end
  endtask

  task automatic test_after_end();
    beat_t bt;
    repeat (6) begin
      bt.kind = 1'($urandom); bt.data = 8'($urandom); bt.last = 1'($urandom);
      send_beat(bt);
    end
    in_tvalid <= 1'b0;
  endtask

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    decoded_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected beat: tdata %h tuser %b tlast %b",
                                  out_tdata, out_tuser, out_tlast);
      end else begin
        e = decoded_q.pop_front();
        if (out_tdata[7:0] !== e.ob || out_tuser !== e.valid || out_tlast !== e.done ||
            out_tdata[11:8] !== e.st || out_tdata[12] !== e.pend ||
            out_tdata[15:13] !== 3'b000) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: expected byte %h valid %b done %b status %0d pend %b, got %h",
                     e.ob, e.valid, e.done, e.st, e.pend,
                     {out_tdata, out_tuser, out_tlast});
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= REG_KEYED;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    in_tlast <= 1'b0;
    out_tready <= 1'b1;
    m_keyed = 1'b1;
    m_key_phase = 0;
    m_size = 0;
    ph = PH_HDR;
    send_idle = 0;
    stall_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_setup();
    test_stream_phases();
    test_after_end();
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
